[design/fsc_pkg.sv]
package fsc_pkg;

  localparam int SEG_COUNT = 7;
  localparam int DIGIT_COUNT_DEF = 6;
  localparam int REQUEST_DEPTH_DEF = 64;
  localparam int ACTIVE_DEPTH_DEF = 16;

  localparam logic [15:0] PULSE_TIME_RST = 16'd100;
  localparam logic [4:0] MAX_ACTIVE_RST = 5'd4;

  // register index taken from the word address
  localparam logic REG_PULSE_TIME = 1'b0;
  localparam logic REG_MAX_ACTIVE = 1'b1;

  typedef enum logic [2:0] {
    OP_SET_DIGIT = 3'd0,
    OP_CLEAR_FORCED = 3'd1,
    OP_CLEAR_UNFORCED = 3'd2,
    OP_CLEAR_ALL = 3'd3,
    OP_TICK = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_START_CHECK,
    S_START_EVAL,
    S_OFF_CHECK,
    S_OFF_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic forced;
    logic value;
    logic [2:0] segment;
    logic [2:0] digit;
  } pending_entry_t;

  typedef struct packed {
    logic [2:0] digit;
    logic [2:0] segment;
    logic value;
    logic [31:0] deadline;
  } active_entry_t;

  typedef struct packed {
    logic [2:0] digit;
    logic [2:0] segment;
    logic polarity;
    logic energize;
  } result_t;

endpackage

[design/fsc_ram.sv]
module fsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/flip_segment_coil_scheduler_unit.sv]
// Coil pulse scheduler for a flip-segment display. One item is handled at a time;
// in_ready is high only while the block is idle. Set digit and clear digit write
// one pending-queue entry per segment while the queue has room; clear all empties
// the pending queue and writes one for every segment of every digit. In a tick
// each queue step is a read of the request or active memory, in flight during a
// check state, followed by an evaluate state; a tick stalls while the output
// register is full and not taken. The queues live in two RAMs with no clearing
// pass after reset; counts and heads select the live entries. Results of a tick
// leave one beat at a time, last set on the final one.
module flip_segment_coil_scheduler_unit #(
  parameter int DIGIT_COUNT = fsc_pkg::DIGIT_COUNT_DEF,
  parameter int REQUEST_DEPTH = fsc_pkg::REQUEST_DEPTH_DEF,
  parameter int ACTIVE_DEPTH = fsc_pkg::ACTIVE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [2:0]  digit,
  input  logic [6:0]  pattern,
  input  logic [31:0] now_ms,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  drive_digit,
  output logic [2:0]  drive_segment,
  output logic        polarity,
  output logic        energize,
  output logic        last,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PIW = $clog2(REQUEST_DEPTH);
  localparam int PCW = PIW + 1;
  localparam int AIW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
  localparam int ACW = AIW + 1;
  localparam int SHOWN_W = DIGIT_COUNT * fsc_pkg::SEG_COUNT;
  localparam int SPW = (SHOWN_W > 1) ? $clog2(SHOWN_W) : 1;
  localparam int PEW = $bits(fsc_pkg::pending_entry_t);
  localparam int AEW = $bits(fsc_pkg::active_entry_t);

  // configuration registers
  logic [15:0] pulse_time;
  logic [4:0] max_active;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == fsc_pkg::REG_MAX_ACTIVE) ? 32'(max_active) : 32'(pulse_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_time <= fsc_pkg::PULSE_TIME_RST;
      max_active <= fsc_pkg::MAX_ACTIVE_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == fsc_pkg::REG_MAX_ACTIVE) begin
        max_active <= pwdata[4:0];
      end else begin
        pulse_time <= pwdata[15:0];
      end
    end
  end

  fsc_pkg::state_t state, state_next;
  fsc_pkg::op_t op, op_next;
  logic [2:0] wdig, wdig_next;
  logic [2:0] wseg, wseg_next;
  logic [6:0] pat, pat_next;
  logic [31:0] now, now_next;
  logic [PIW-1:0] phead, phead_next;
  logic [PCW-1:0] pcount, pcount_next;
  logic [AIW-1:0] ahead, ahead_next;
  logic [ACW-1:0] acount, acount_next;
  logic [SHOWN_W-1:0] shown, shown_next;
  logic flush, flush_next;
  fsc_pkg::result_t hold, hold_next;
  logic hold_valid, hold_valid_next;
  fsc_pkg::result_t res, res_next;
  logic res_last, res_last_next;
  logic out_valid_next;

  // memory ports
  logic pwe, awe;
  logic [PIW-1:0] pwaddr;
  logic [AIW-1:0] awaddr;
  fsc_pkg::pending_entry_t pwentry, prentry;
  fsc_pkg::active_entry_t awentry, arentry;
  logic [PEW-1:0] prdata_raw;
  logic [AEW-1:0] ardata_raw;

  // queue tails, wrapped by one conditional subtract
  logic [PIW:0] ptail_sum;
  logic [AIW:0] atail_sum;
  logic [PIW:0] ptail_wrap;
  logic [AIW:0] atail_wrap;

  assign ptail_sum = (PIW + 1)'(phead) + (PIW + 1)'(pcount);
  assign atail_sum = (AIW + 1)'(ahead) + (AIW + 1)'(acount);
  assign ptail_wrap = (ptail_sum >= (PIW + 1)'(REQUEST_DEPTH))
                      ? ptail_sum - (PIW + 1)'(REQUEST_DEPTH) : ptail_sum;
  assign atail_wrap = (atail_sum >= (AIW + 1)'(ACTIVE_DEPTH))
                      ? atail_sum - (AIW + 1)'(ACTIVE_DEPTH) : atail_sum;
  assign pwaddr = ptail_wrap[PIW-1:0];
  assign awaddr = atail_wrap[AIW-1:0];

  assign prentry = fsc_pkg::pending_entry_t'(prdata_raw);
  assign arentry = fsc_pkg::active_entry_t'(ardata_raw);

  fsc_ram #(
    .WIDTH(PEW),
    .DEPTH(REQUEST_DEPTH)
  ) u_pending_ram (
    .clk  (clk),
    .we   (pwe),
    .waddr(pwaddr),
    .wdata(PEW'(pwentry)),
    .raddr(phead),
    .rdata(prdata_raw)
  );

  fsc_ram #(
    .WIDTH(AEW),
    .DEPTH(ACTIVE_DEPTH)
  ) u_active_ram (
    .clk  (clk),
    .we   (awe),
    .waddr(awaddr),
    .wdata(AEW'(awentry)),
    .raddr(ahead),
    .rdata(ardata_raw)
  );

  assign in_ready = (state == fsc_pkg::S_IDLE);

  logic out_free;
  logic can_emit;
  logic start_ok;
  logic [5:0] pos_full;
  logic [SPW-1:0] pos;
  logic cur;
  fsc_pkg::result_t new_res;

  assign out_free = !out_valid || out_ready;
  assign can_emit = !hold_valid || out_free;
  assign pos_full = 6'(prentry.digit) * 6'(fsc_pkg::SEG_COUNT) + 6'(prentry.segment);
  assign pos = pos_full[SPW-1:0];
  assign cur = shown[pos];
  assign start_ok = (32'(acount) < 32'(max_active)) && (32'(acount) < ACTIVE_DEPTH)
                    && (pcount != '0) && !flush;

  always_comb begin
    state_next = state;
    op_next = op;
    wdig_next = wdig;
    wseg_next = wseg;
    pat_next = pat;
    now_next = now;
    phead_next = phead;
    pcount_next = pcount;
    ahead_next = ahead;
    acount_next = acount;
    shown_next = shown;
    flush_next = flush;
    hold_next = hold;
    hold_valid_next = hold_valid;
    res_next = res;
    res_last_next = res_last;
    out_valid_next = out_valid && !out_ready;
    pwe = 1'b0;
    awe = 1'b0;
    pwentry = '0;
    awentry = '0;
    new_res = '0;

    unique case (state)
      fsc_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next = fsc_pkg::op_t'(operation);
          pat_next = pattern;
          now_next = now_ms;
          wdig_next = digit;
          wseg_next = '0;
          unique case (fsc_pkg::op_t'(operation))
            fsc_pkg::OP_SET_DIGIT: begin
              if (pattern != '0 && 32'(digit) < DIGIT_COUNT) begin
                state_next = fsc_pkg::S_WRITE;
              end
            end
            fsc_pkg::OP_CLEAR_FORCED, fsc_pkg::OP_CLEAR_UNFORCED: begin
              if (32'(digit) < DIGIT_COUNT) begin
                state_next = fsc_pkg::S_WRITE;
              end
            end
            fsc_pkg::OP_CLEAR_ALL: begin
              pcount_next = '0;
              phead_next = '0;
              flush_next = 1'b1;
              wdig_next = '0;
              state_next = fsc_pkg::S_WRITE;
            end
            fsc_pkg::OP_TICK: begin
              state_next = fsc_pkg::S_START_CHECK;
            end
            default: begin
            end
          endcase
        end
      end

      fsc_pkg::S_WRITE: begin
        pwentry.digit = wdig;
        pwentry.segment = wseg;
        pwentry.value = (op == fsc_pkg::OP_SET_DIGIT) ? pat[wseg] : 1'b0;
        pwentry.forced = (op == fsc_pkg::OP_CLEAR_FORCED) || (op == fsc_pkg::OP_CLEAR_ALL);
        if (pcount < PCW'(REQUEST_DEPTH)) begin
          pwe = 1'b1;
          pcount_next = pcount + 1'b1;
        end
        if (wseg == 3'(fsc_pkg::SEG_COUNT - 1)) begin
          wseg_next = '0;
          if (op == fsc_pkg::OP_CLEAR_ALL && wdig != 3'(DIGIT_COUNT - 1)) begin
            wdig_next = wdig + 1'b1;
          end else begin
            state_next = fsc_pkg::S_IDLE;
          end
        end else begin
          wseg_next = wseg + 1'b1;
        end
      end

      fsc_pkg::S_START_CHECK: begin
        // request memory read of the head entry is in flight this cycle
        state_next = start_ok ? fsc_pkg::S_START_EVAL : fsc_pkg::S_OFF_CHECK;
      end

      fsc_pkg::S_START_EVAL: begin
        new_res.digit = prentry.digit;
        new_res.segment = prentry.segment;
        new_res.polarity = prentry.value;
        new_res.energize = 1'b1;
        if (!(prentry.forced || cur != prentry.value) || can_emit) begin
          phead_next = (phead == PIW'(REQUEST_DEPTH - 1)) ? '0 : phead + 1'b1;
          pcount_next = pcount - 1'b1;
          state_next = fsc_pkg::S_START_CHECK;
          if (prentry.forced || cur != prentry.value) begin
            shown_next[pos] = prentry.value;
            awe = 1'b1;
            awentry.digit = prentry.digit;
            awentry.segment = prentry.segment;
            awentry.value = prentry.value;
            awentry.deadline = now + 32'(pulse_time);
            acount_next = acount + 1'b1;
            if (hold_valid) begin
              res_next = hold;
              res_last_next = 1'b0;
              out_valid_next = 1'b1;
            end
            hold_next = new_res;
            hold_valid_next = 1'b1;
          end
        end
      end

      fsc_pkg::S_OFF_CHECK: begin
        state_next = (acount != '0) ? fsc_pkg::S_OFF_EVAL : fsc_pkg::S_DONE;
      end

      fsc_pkg::S_OFF_EVAL: begin
        new_res.digit = arentry.digit;
        new_res.segment = arentry.segment;
        new_res.polarity = arentry.value;
        new_res.energize = 1'b0;
        if (arentry.deadline > now) begin
          state_next = fsc_pkg::S_DONE;
        end else if (can_emit) begin
          ahead_next = (ahead == AIW'(ACTIVE_DEPTH - 1)) ? '0 : ahead + 1'b1;
          acount_next = acount - 1'b1;
          if (hold_valid) begin
            res_next = hold;
            res_last_next = 1'b0;
            out_valid_next = 1'b1;
          end
          hold_next = new_res;
          hold_valid_next = 1'b1;
          state_next = fsc_pkg::S_OFF_CHECK;
        end
      end

      fsc_pkg::S_DONE: begin
        if (acount == '0) begin
          flush_next = 1'b0;
        end
        // the held beat is the final one of this tick
        if (!hold_valid) begin
          state_next = fsc_pkg::S_IDLE;
        end else if (out_free) begin
          res_next = hold;
          res_last_next = 1'b1;
          out_valid_next = 1'b1;
          hold_valid_next = 1'b0;
          state_next = fsc_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = fsc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsc_pkg::S_IDLE;
      phead <= '0;
      pcount <= '0;
      ahead <= '0;
      acount <= '0;
      shown <= '0;
      flush <= 1'b0;
      hold_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phead <= phead_next;
      pcount <= pcount_next;
      ahead <= ahead_next;
      acount <= acount_next;
      shown <= shown_next;
      flush <= flush_next;
      hold_valid <= hold_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    wdig <= wdig_next;
    wseg <= wseg_next;
    pat <= pat_next;
    now <= now_next;
    hold <= hold_next;
    res <= res_next;
    res_last <= res_last_next;
  end

  assign drive_digit = res.digit;
  assign drive_segment = res.segment;
  assign polarity = res.polarity;
  assign energize = res.energize;
  assign last = res_last;

endmodule
